/* rtl/core/rbes_pkg.sv */
// Shared types, constants and the micro-op table of the rigid body Euler step.
// Used by rbes_div, rbes_dp, rbes_ctrl and rigid_body_euler_step.
package rbes_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DT_BITS   = 16;
  localparam int unsigned DT_FRAC   = 16;
  localparam int unsigned SLOT_BITS = 5;
  localparam int unsigned ADDR_BITS = 6;
  localparam int unsigned MEM_DEPTH = 48;
  localparam int unsigned NUM_WORDS = 27;
  localparam int unsigned NUM_LOAD  = 18;
  localparam int unsigned NUM_UOPS  = 78;
  localparam int unsigned UOP_BITS  = 7;
  localparam int unsigned NUM_INV   = 9;
  localparam int unsigned NUM_ACCEL = 6;
  localparam int unsigned DIV_BITS  = WORD_BITS + FRAC_BITS;
  localparam int unsigned PROD_BITS = 2 * WORD_BITS;
  localparam int unsigned ACC_BITS  = WORD_BITS + 2;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic signed [WORD_BITS-1:0] word_t;

  // Storage map: state words, then scratch for omega*dt, the orientation
  // delta and the cofactors. The determinant has its own register.
  localparam addr_t A_POS  = addr_t'(0);
  localparam addr_t A_LVEL = addr_t'(3);
  localparam addr_t A_RVEL = addr_t'(6);
  localparam addr_t A_ORI  = addr_t'(9);
  localparam addr_t A_INV  = addr_t'(18);
  localparam addr_t A_W    = addr_t'(27);
  localparam addr_t A_D    = addr_t'(30);
  localparam addr_t A_C    = addr_t'(39);
  localparam addr_t A_DET  = addr_t'(48);

  localparam word_t ONE_Q = word_t'(1 << FRAC_BITS);
  localparam word_t W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic {REQ_STEP = 1'b0, REQ_LOAD = 1'b1} req_e;
  typedef enum logic {ASRC_MEM, ASRC_ACCEL} asrc_e;
  typedef enum logic [1:0] {BSRC_MEM, BSRC_DT, BSRC_ONE} bsrc_e;
  typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} accm_e;

  typedef struct packed {
    asrc_e a_src;
    addr_t a_addr;
    bsrc_e b_src;
    addr_t b_addr;
    logic  sh_dt;
    accm_e mode;
    logic  wr;
    addr_t dst;
  } uop_t;

  typedef struct packed {
    logic                 req_type;
    logic [DT_BITS-1:0]   step_dt;
    word_t                lin_acc_x;
    word_t                lin_acc_y;
    word_t                lin_acc_z;
    word_t                rot_acc_x;
    word_t                rot_acc_y;
    word_t                rot_acc_z;
    logic [SLOT_BITS-1:0] load_slot;
    word_t                load_word;
  } in_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] word_slot;
    word_t                word_value;
    logic                 singular;
    logic                 last_word;
  } out_t;

  typedef struct packed {
    logic                 take_step;
    logic                 take_load;
    addr_t                rd_a;
    addr_t                rd_b;
    logic                 mul_en;
    logic                 rnd_en;
    logic                 acc_en;
    uop_t                 uop;
    logic                 chk;
    logic                 div_start;
    logic                 div_wr;
    logic [3:0]           div_k;
    logic                 out_load;
    logic [SLOT_BITS-1:0] out_slot;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

  // Row and column of a 3x3 entry, packed as {row, col}.
  function automatic logic [3:0] rc3(input logic [3:0] e);
    logic [3:0] rc;
    case (e)
      4'd0:    rc = {2'd0, 2'd0};
      4'd1:    rc = {2'd0, 2'd1};
      4'd2:    rc = {2'd0, 2'd2};
      4'd3:    rc = {2'd1, 2'd0};
      4'd4:    rc = {2'd1, 2'd1};
      4'd5:    rc = {2'd1, 2'd2};
      4'd6:    rc = {2'd2, 2'd0};
      4'd7:    rc = {2'd2, 2'd1};
      4'd8:    rc = {2'd2, 2'd2};
      default: rc = {2'd0, 2'd0};
    endcase
    return rc;
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] x);
    logic [1:0] y;
    case (x)
      2'd0:    y = 2'd1;
      2'd1:    y = 2'd2;
      default: y = 2'd0;
    endcase
    return y;
  endfunction

  function automatic addr_t mat_addr(input addr_t base, input logic [1:0] r,
                                     input logic [1:0] c);
    return base + addr_t'({r, 1'b0}) + addr_t'(r) + addr_t'(c);
  endfunction

  // Cofactor address feeding inverse entry k (transposed).
  function automatic addr_t tr_addr(input logic [3:0] k);
    logic [3:0] rc;
    rc = rc3(k);
    return mat_addr(A_C, rc[1:0], rc[3:2]);
  endfunction

  // Micro-op program of one integration step.
  function automatic uop_t uop_at(input logic [UOP_BITS-1:0] idx);
    uop_t       u;
    logic [UOP_BITS-1:0] p;
    logic [3:0] e;
    logic [3:0] rc;
    logic [1:0] r, j, r1, r2, j1, j2;
    u = '0;
    u.a_src = ASRC_MEM;
    u.b_src = BSRC_ONE;
    u.mode  = ACC_LOAD;
    if (idx < UOP_BITS'(6)) begin
      p = idx;
      if (!p[0]) begin
        u.a_addr = A_LVEL + addr_t'(p[2:1]);
      end else begin
        u.a_src  = ASRC_ACCEL;
        u.a_addr = addr_t'(p[2:1]);
        u.b_src  = BSRC_DT;
        u.sh_dt  = 1'b1;
        u.mode   = ACC_ADD;
        u.wr     = 1'b1;
        u.dst    = A_LVEL + addr_t'(p[2:1]);
      end
    end else if (idx < UOP_BITS'(12)) begin
      p = idx - UOP_BITS'(6);
      if (!p[0]) begin
        u.a_addr = A_RVEL + addr_t'(p[2:1]);
      end else begin
        u.a_src  = ASRC_ACCEL;
        u.a_addr = addr_t'(3) + addr_t'(p[2:1]);
        u.b_src  = BSRC_DT;
        u.sh_dt  = 1'b1;
        u.mode   = ACC_ADD;
        u.wr     = 1'b1;
        u.dst    = A_RVEL + addr_t'(p[2:1]);
      end
    end else if (idx < UOP_BITS'(18)) begin
      p = idx - UOP_BITS'(12);
      if (!p[0]) begin
        u.a_addr = A_POS + addr_t'(p[2:1]);
      end else begin
        u.a_addr = A_LVEL + addr_t'(p[2:1]);
        u.b_src  = BSRC_DT;
        u.sh_dt  = 1'b1;
        u.mode   = ACC_ADD;
        u.wr     = 1'b1;
        u.dst    = A_POS + addr_t'(p[2:1]);
      end
    end else if (idx < UOP_BITS'(21)) begin
      p = idx - UOP_BITS'(18);
      u.a_addr = A_RVEL + addr_t'(p[1:0]);
      u.b_src  = BSRC_DT;
      u.sh_dt  = 1'b1;
      u.wr     = 1'b1;
      u.dst    = A_W + addr_t'(p[1:0]);
    end else if (idx < UOP_BITS'(39)) begin
      p  = idx - UOP_BITS'(21);
      e  = p[4:1];
      rc = rc3(e);
      r  = rc[3:2];
      j  = rc[1:0];
      r1 = inc3(r);
      r2 = inc3(r1);
      u.b_src = BSRC_MEM;
      if (!p[0]) begin
        u.a_addr = A_W + addr_t'(r1);
        u.b_addr = mat_addr(A_ORI, r2, j);
      end else begin
        u.a_addr = A_W + addr_t'(r2);
        u.b_addr = mat_addr(A_ORI, r1, j);
        u.mode   = ACC_SUB;
        u.wr     = 1'b1;
        u.dst    = A_D + addr_t'(e);
      end
    end else if (idx < UOP_BITS'(57)) begin
      p = idx - UOP_BITS'(39);
      e = p[4:1];
      if (!p[0]) begin
        u.a_addr = A_ORI + addr_t'(e);
      end else begin
        u.a_addr = A_D + addr_t'(e);
        u.mode   = ACC_ADD;
        u.wr     = 1'b1;
        u.dst    = A_ORI + addr_t'(e);
      end
    end else if (idx < UOP_BITS'(75)) begin
      p  = idx - UOP_BITS'(57);
      e  = p[4:1];
      rc = rc3(e);
      r1 = inc3(rc[3:2]);
      r2 = inc3(r1);
      j1 = inc3(rc[1:0]);
      j2 = inc3(j1);
      u.b_src = BSRC_MEM;
      if (!p[0]) begin
        u.a_addr = mat_addr(A_ORI, r1, j1);
        u.b_addr = mat_addr(A_ORI, r2, j2);
      end else begin
        u.a_addr = mat_addr(A_ORI, r1, j2);
        u.b_addr = mat_addr(A_ORI, r2, j1);
        u.mode   = ACC_SUB;
        u.wr     = 1'b1;
        u.dst    = A_C + addr_t'(e);
      end
    end else begin
      p = idx - UOP_BITS'(75);
      u.a_addr = A_ORI + addr_t'(p[1:0]);
      u.b_src  = BSRC_MEM;
      u.b_addr = A_C + addr_t'(p[1:0]);
      u.mode   = (p[1:0] == 2'd0) ? ACC_LOAD : ACC_ADD;
      u.wr     = (p[1:0] == 2'd2);
      u.dst    = A_DET;
    end
    return u;
  endfunction

endpackage

/* rtl/core/rbes_div.sv */
// Restoring divider, one quotient bit per cycle, signed with saturation.
// Depends on rbes_pkg.
module rbes_div import rbes_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t num_i,
  input  word_t den_i,
  output logic  busy_o,
  output logic  done_o,
  output word_t quo_o
);

  localparam int unsigned CNT_BITS = $clog2(DIV_BITS);
  localparam logic [DIV_BITS-1:0] MAG_MAX =
    {{(FRAC_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic [DIV_BITS-1:0] MAG_MIN =
    {{FRAC_BITS{1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};

  logic                 busy_q, done_q, neg_q;
  logic [CNT_BITS-1:0]  cnt_q;
  logic [WORD_BITS-1:0] rem_q, den_q;
  logic [DIV_BITS-1:0]  quo_q;
  logic [WORD_BITS:0]   trial, diff;
  logic                 ge;
  logic [WORD_BITS-1:0] nmag, dmag;

  assign nmag  = num_i[WORD_BITS-1] ? WORD_BITS'(-num_i) : WORD_BITS'(num_i);
  assign dmag  = den_i[WORD_BITS-1] ? WORD_BITS'(-den_i) : WORD_BITS'(den_i);
  assign trial = {rem_q, quo_q[DIV_BITS-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(DIV_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= {nmag, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      den_q <= dmag;
      neg_q <= num_i[WORD_BITS-1] ^ den_i[WORD_BITS-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      quo_q <= {quo_q[DIV_BITS-2:0], ge};
    end
  end

  // Apply sign, clamp to the word range.
  always_comb begin
    if (!neg_q) begin
      quo_o = (quo_q > MAG_MAX) ? W_MAX : word_t'(quo_q[WORD_BITS-1:0]);
    end else begin
      quo_o = (quo_q > MAG_MIN) ? W_MIN : word_t'(-quo_q[WORD_BITS-1:0]);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
`endif

endmodule

/* rtl/core/rbes_dp.sv */
// Datapath: state storage, shared multiplier with round and saturate,
// accumulator, divider and output register. Depends on rbes_pkg, rbes_div.
module rbes_dp import rbes_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  input  logic out_stall_i,
  output sts_t sts_o,
  output logic out_valid_o,
  output out_t out_data_o
);

  localparam logic signed [PROD_BITS-1:0] P_MAX =
    {{(PROD_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [PROD_BITS-1:0] P_MIN =
    {{(PROD_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] A_MAX =
    {{(ACC_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] A_MIN =
    {{(ACC_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [PROD_BITS-1:0] HALF_FB = PROD_BITS'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_BITS-1:0] HALF_DT = PROD_BITS'(1) << (DT_FRAC - 1);

  function automatic word_t sat_prod(input logic signed [PROD_BITS-1:0] x);
    if (x > P_MAX) return W_MAX;
    if (x < P_MIN) return W_MIN;
    return word_t'(x[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sat_acc(input logic signed [ACC_BITS-1:0] x);
    if (x > A_MAX) return W_MAX;
    if (x < A_MIN) return W_MIN;
    return word_t'(x[WORD_BITS-1:0]);
  endfunction

  function automatic word_t rst_word(input addr_t a);
    if (a inside {addr_t'(9), addr_t'(13), addr_t'(17),
                  addr_t'(18), addr_t'(22), addr_t'(26)}) return ONE_Q;
    return '0;
  endfunction

  word_t                         mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]          vld_q;
  word_t                         rda_q, rdb_q;
  logic [DT_BITS-1:0]            dt_q;
  word_t                         accel_q [NUM_ACCEL];
  logic signed [PROD_BITS-1:0]   prod_q, a_ext, b_ext, rnd, shf;
  word_t                         m_q, opa, opb, det_q, div_q;
  logic signed [ACC_BITS-1:0]    acc_q, acc_d, m_ext;
  logic                          sing_q, out_valid_q, out_free;
  out_t                          out_q;
  logic                          wr_en;
  addr_t                         wr_addr;
  word_t                         wr_data;
  logic                          div_busy, div_done;

  // Write port: load, micro-op result, quotient.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd_i.take_load && (in_data_i.load_slot < SLOT_BITS'(NUM_LOAD))) begin
      wr_en   = 1'b1;
      wr_addr = addr_t'(in_data_i.load_slot);
      wr_data = in_data_i.load_word;
    end else if (cmd_i.acc_en && cmd_i.uop.wr && (cmd_i.uop.dst != A_DET)) begin
      wr_en   = 1'b1;
      wr_addr = cmd_i.uop.dst;
      wr_data = sat_acc(acc_d);
    end else if (cmd_i.div_wr) begin
      wr_en   = 1'b1;
      wr_addr = A_INV + addr_t'(cmd_i.div_k);
      wr_data = div_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rda_q <= vld_q[cmd_i.rd_a] ? mem_q[cmd_i.rd_a] : rst_word(cmd_i.rd_a);
    rdb_q <= vld_q[cmd_i.rd_b] ? mem_q[cmd_i.rd_b] : rst_word(cmd_i.rd_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // Step operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_step) begin
      dt_q       <= in_data_i.step_dt;
      accel_q[0] <= in_data_i.lin_acc_x;
      accel_q[1] <= in_data_i.lin_acc_y;
      accel_q[2] <= in_data_i.lin_acc_z;
      accel_q[3] <= in_data_i.rot_acc_x;
      accel_q[4] <= in_data_i.rot_acc_y;
      accel_q[5] <= in_data_i.rot_acc_z;
    end
  end

  always_comb begin
    opa = (cmd_i.uop.a_src == ASRC_ACCEL) ? accel_q[cmd_i.uop.a_addr[2:0]] : rda_q;
    case (cmd_i.uop.b_src)
      BSRC_MEM: opb = rdb_q;
      BSRC_DT:  opb = word_t'({{(WORD_BITS-DT_BITS){1'b0}}, dt_q});
      default:  opb = ONE_Q;
    endcase
    a_ext = {{(PROD_BITS-WORD_BITS){opa[WORD_BITS-1]}}, opa};
    b_ext = {{(PROD_BITS-WORD_BITS){opb[WORD_BITS-1]}}, opb};
    rnd   = prod_q + (cmd_i.uop.sh_dt ? HALF_DT : HALF_FB);
    shf   = cmd_i.uop.sh_dt ? (rnd >>> DT_FRAC) : (rnd >>> FRAC_BITS);
    m_ext = {{(ACC_BITS-WORD_BITS){m_q[WORD_BITS-1]}}, m_q};
    case (cmd_i.uop.mode)
      ACC_ADD: acc_d = acc_q + m_ext;
      ACC_SUB: acc_d = acc_q - m_ext;
      default: acc_d = m_ext;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= a_ext * b_ext;
    if (cmd_i.rnd_en) m_q <= sat_prod(shf);
    if (cmd_i.acc_en) begin
      acc_q <= acc_d;
      if (cmd_i.uop.wr && (cmd_i.uop.dst == A_DET)) det_q <= sat_acc(acc_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sing_q <= 1'b0;
    end else if (cmd_i.chk) begin
      sing_q <= (det_q == '0);
    end
  end

  rbes_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (rda_q),
    .den_i   (det_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.word_slot  <= cmd_i.out_slot;
      out_q.word_value <= rda_q;
      out_q.singular   <= sing_q;
      out_q.last_word  <= (cmd_i.out_slot == SLOT_BITS'(NUM_WORDS - 1));
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.det_zero  = (det_q == '0);
  assign sts_o.div_busy  = div_busy;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = out_free;

`ifndef ASSERT_OFF
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free) else $error("output overwritten while stalled");
  a_div_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_wr |-> !sing_q) else $error("inverse written on singular step");
`endif

endmodule

/* rtl/core/rbes_ctrl.sv */
// Sequencer: runs the micro-op program, the inverse divisions and the
// word emission. Depends on rbes_pkg.
module rbes_ctrl import rbes_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic req_type_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_OP_RD, ST_OP_MUL, ST_OP_RND, ST_OP_ACC, ST_CHK,
    ST_DV_RD, ST_DV_LD, ST_DV_RUN, ST_EM_RD, ST_EM_OUT
  } state_e;

  state_e               state_q;
  logic [UOP_BITS-1:0]  idx_q;
  logic [SLOT_BITS-1:0] k_q;
  uop_t                 uop;

  assign uop        = uop_at(idx_q);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.uop      = uop;
    cmd_o.div_k    = k_q[3:0];
    cmd_o.out_slot = k_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take_step = in_valid_i && (req_type_i == REQ_STEP);
        cmd_o.take_load = in_valid_i && (req_type_i == REQ_LOAD);
      end
      ST_OP_RD, ST_OP_MUL, ST_OP_RND, ST_OP_ACC: begin
        cmd_o.rd_a   = uop.a_addr;
        cmd_o.rd_b   = uop.b_addr;
        cmd_o.mul_en = (state_q == ST_OP_MUL);
        cmd_o.rnd_en = (state_q == ST_OP_RND);
        cmd_o.acc_en = (state_q == ST_OP_ACC);
      end
      ST_CHK: cmd_o.chk = 1'b1;
      ST_DV_RD, ST_DV_LD: begin
        cmd_o.rd_a      = tr_addr(k_q[3:0]);
        cmd_o.div_start = (state_q == ST_DV_LD);
      end
      ST_DV_RUN: cmd_o.div_wr = sts_i.div_done;
      ST_EM_RD, ST_EM_OUT: begin
        cmd_o.rd_a     = addr_t'(k_q);
        cmd_o.out_load = (state_q == ST_EM_OUT) && sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      k_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && (req_type_i == REQ_STEP)) begin
            idx_q   <= '0;
            state_q <= ST_OP_RD;
          end
        end
        ST_OP_RD:  state_q <= ST_OP_MUL;
        ST_OP_MUL: state_q <= ST_OP_RND;
        ST_OP_RND: state_q <= ST_OP_ACC;
        ST_OP_ACC: begin
          if (idx_q == UOP_BITS'(NUM_UOPS - 1)) begin
            state_q <= ST_CHK;
          end else begin
            idx_q   <= idx_q + UOP_BITS'(1);
            state_q <= ST_OP_RD;
          end
        end
        ST_CHK: begin
          k_q     <= '0;
          state_q <= sts_i.det_zero ? ST_EM_RD : ST_DV_RD;
        end
        ST_DV_RD: state_q <= ST_DV_LD;
        ST_DV_LD: state_q <= ST_DV_RUN;
        ST_DV_RUN: begin
          if (sts_i.div_done) begin
            if (k_q == SLOT_BITS'(NUM_INV - 1)) begin
              k_q     <= '0;
              state_q <= ST_EM_RD;
            end else begin
              k_q     <= k_q + SLOT_BITS'(1);
              state_q <= ST_DV_RD;
            end
          end
        end
        ST_EM_RD: state_q <= ST_EM_OUT;
        ST_EM_OUT: begin
          if (sts_i.out_free) begin
            if (k_q == SLOT_BITS'(NUM_WORDS - 1)) begin
              state_q <= ST_IDLE;
            end else begin
              k_q     <= k_q + SLOT_BITS'(1);
              state_q <= ST_EM_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OP_ACC) |-> (idx_q < UOP_BITS'(NUM_UOPS)))
    else $error("micro-op index out of range");
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EM_OUT) |-> (k_q < SLOT_BITS'(NUM_WORDS)))
    else $error("emit index out of range");
`endif

endmodule

/* rtl/core/rigid_body_euler_step.sv */
// A load transaction is taken while idle and emits nothing. A step runs 78
// micro-ops, each through read, multiply, round and accumulate states on the
// shared multiplier, a check state, 9 inverse entries on the one-bit-a-cycle
// divider unless the determinant is zero, then 27 words. Throughput: one
// transaction at a time. Reset: asynchronous, active low; position and
// velocities read as zero, orientation and inverse as identity.
module rigid_body_euler_step import rbes_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns the schedule, stalls input while a step is in flight.
  rbes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Datapath: storage, multiplier, accumulator, divider, output register.
  rbes_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

/* verif/rigid_body_euler_step_checker.sv */
// Checker for rigid_body_euler_step: watches both valid/stall channels,
// predicts the 27 words of each step and compares. Depends on rbes_pkg.
module rigid_body_euler_step_checker import rbes_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   err_count_o,
  output int   words_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  longint body_p[3];
  longint body_lv[3];
  longint body_av[3];
  longint body_r[9];
  longint body_ri[9];
  out_t   word_expect_q[$];

  assign words_pending_o = word_expect_q.size();

  function automatic longint clamp_word(input longint x);
    if (x > WMAX) return WMAX;
    if (x < WMIN) return WMIN;
    return x;
  endfunction

  // Exact product, round half up, floor shift, saturate.
  function automatic longint prod_round(input longint a, input longint b, input int fb);
    longint p;
    p = a * b + (64'sd1 <<< (fb - 1));
    return clamp_word(p >>> fb);
  endfunction

  function automatic void push_word(input int k, input longint v, input logic sing);
    out_t w;
    w.word_slot  = SLOT_BITS'(k);
    w.word_value = word_t'(v);
    w.singular   = sing;
    w.last_word  = (k == NUM_WORDS - 1);
    word_expect_q.push_back(w);
  endfunction

  function automatic void integrate(input in_t t);
    longint dt, det, num;
    longint om[3];
    longint dl[9];
    longint cof[9];
    longint la[3];
    longint ra[3];
    logic   sing;
    int     i1, i2, j1, j2;
    dt = longint'(t.step_dt);
    la[0] = t.lin_acc_x; la[1] = t.lin_acc_y; la[2] = t.lin_acc_z;
    ra[0] = t.rot_acc_x; ra[1] = t.rot_acc_y; ra[2] = t.rot_acc_z;
    sing = 1'b0;
    // Velocities first, then position with the new velocity.
    for (int i = 0; i < 3; i++) begin
      body_lv[i] = clamp_word(body_lv[i] + prod_round(la[i], dt, DT_FRAC));
      body_av[i] = clamp_word(body_av[i] + prod_round(ra[i], dt, DT_FRAC));
    end
    for (int i = 0; i < 3; i++) begin
      body_p[i] = clamp_word(body_p[i] + prod_round(body_lv[i], dt, DT_FRAC));
      om[i] = prod_round(body_av[i], dt, DT_FRAC);
    end
    // Orientation delta = skew(omega*dt) * R.
    for (int j = 0; j < 3; j++) begin
      dl[j]   = clamp_word(prod_round(om[1], body_r[6+j], FRAC_BITS)
                         - prod_round(om[2], body_r[3+j], FRAC_BITS));
      dl[3+j] = clamp_word(prod_round(om[2], body_r[j], FRAC_BITS)
                         - prod_round(om[0], body_r[6+j], FRAC_BITS));
      dl[6+j] = clamp_word(prod_round(om[0], body_r[3+j], FRAC_BITS)
                         - prod_round(om[1], body_r[j], FRAC_BITS));
    end
    for (int i = 0; i < 9; i++) body_r[i] = clamp_word(body_r[i] + dl[i]);
    for (int i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3;
      i2 = (i + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        cof[i*3+j] = clamp_word(prod_round(body_r[i1*3+j1], body_r[i2*3+j2], FRAC_BITS)
                              - prod_round(body_r[i1*3+j2], body_r[i2*3+j1], FRAC_BITS));
      end
    end
    det = 0;
    for (int j = 0; j < 3; j++) det += prod_round(body_r[j], cof[j], FRAC_BITS);
    det = clamp_word(det);
    // Zero determinant: hold the old inverse and flag the step.
    if (det == 0) begin
      sing = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          num = cof[j*3+i] * (64'sd1 <<< FRAC_BITS);
          body_ri[i*3+j] = clamp_word(num / det);
        end
    end
    for (int i = 0; i < 3; i++) push_word(i, body_p[i], sing);
    for (int i = 0; i < 3; i++) push_word(3 + i, body_lv[i], sing);
    for (int i = 0; i < 3; i++) push_word(6 + i, body_av[i], sing);
    for (int i = 0; i < 9; i++) push_word(9 + i, body_r[i], sing);
    for (int i = 0; i < 9; i++) push_word(18 + i, body_ri[i], sing);
  endfunction

  function automatic void load_state(input in_t t);
    longint v;
    int     s;
    v = t.load_word;
    s = t.load_slot;
    if (s < 3) body_p[s] = v;
    else if (s < 6) body_lv[s-3] = v;
    else if (s < 9) body_av[s-6] = v;
    else if (s < 18) body_r[s-9] = v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_w;
    if (!rst_ni) begin
      err_count_o = 0;
      word_expect_q.delete();
      for (int i = 0; i < 3; i++) begin
        body_p[i] = 0; body_lv[i] = 0; body_av[i] = 0;
      end
      for (int i = 0; i < 9; i++) begin
        body_r[i]  = (i % 4 == 0) ? (64'sd1 <<< FRAC_BITS) : 0;
        body_ri[i] = body_r[i];
      end
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (word_expect_q.size() == 0) begin
          err_count_o++;
          $display("%0t: unexpected word slot=%0d value=%h", $time,
                   out_data_i.word_slot, out_data_i.word_value);
        end else begin
          exp_w = word_expect_q.pop_front();
          if (out_data_i !== exp_w) begin
            err_count_o++;
            $display("%0t: mismatch expected slot=%0d value=%h sing=%b last=%b",
                     $time, exp_w.word_slot, exp_w.word_value, exp_w.singular,
                     exp_w.last_word);
            $display("%0t:          actual   slot=%0d value=%h sing=%b last=%b",
                     $time, out_data_i.word_slot, out_data_i.word_value,
                     out_data_i.singular, out_data_i.last_word);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.req_type == REQ_LOAD) load_state(in_data_i);
        else integrate(in_data_i);
      end
    end
  end
endmodule

/* verif/rigid_body_euler_step_test.sv */
// Top of the rigid_body_euler_step testbench: clock, reset, stimulus, stall
// pattern and verdict. Depends on rbes_pkg and rigid_body_euler_step_checker.
module rigid_body_euler_step_test import rbes_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TX_TOTAL   = 400;
  localparam int QUIET_FROM = 340;
  localparam int CYCLE_CAP  = 3000000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  int   err_count;
  int   words_pending;
  int   tx_count;
  logic quiet;
  logic drained;
  int   cycle_count;

  rigid_body_euler_step uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  rigid_body_euler_step_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .err_count_o(err_count), .words_pending_o(words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
        $display("[rigid_body_euler_step] ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, none once the tail of the run starts.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Present one transaction and hold it until accepted; maybe idle first.
  task automatic send_tx(input in_t t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_data_i  <= t;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tx_count++;
    if (tx_count >= QUIET_FROM) quiet = 1'b1;
  endtask

  function automatic in_t load_tx(input int slot, input word_t w);
    in_t t;
    t = '0;
    t.req_type  = REQ_LOAD;
    t.load_slot = SLOT_BITS'(slot);
    t.load_word = w;
    // Fill the unused step fields with junk; a load must ignore them.
    t.step_dt   = DT_BITS'($urandom);
    t.lin_acc_x = $urandom;
    t.rot_acc_z = $urandom;
    return t;
  endfunction

  function automatic in_t step_tx(input logic [DT_BITS-1:0] dt, input word_t la,
                                  input word_t ra);
    in_t t;
    t = '0;
    t.req_type  = REQ_STEP;
    t.step_dt   = dt;
    t.lin_acc_x = la;
    t.lin_acc_y = -la;
    t.lin_acc_z = la >>> 3;
    t.rot_acc_x = ra;
    t.rot_acc_y = ra >>> 2;
    t.rot_acc_z = -ra;
    t.load_slot = SLOT_BITS'($urandom);
    t.load_word = $urandom;
    return t;
  endfunction

  // Mostly modest accelerations so the body stays out of saturation.
  function automatic word_t pick_acc();
    if ($urandom_range(0, 9) < 7) return word_t'($urandom_range(0, 1 << 21)) - (1 << 20);
    return word_t'($urandom);
  endfunction

  function automatic in_t random_step();
    in_t t;
    t = step_tx($urandom_range(0, 9) < 8 ? DT_BITS'($urandom_range(0, 4096))
                                         : DT_BITS'($urandom), pick_acc(), pick_acc());
    t.lin_acc_y = pick_acc();
    t.rot_acc_y = pick_acc();
    return t;
  endfunction

  initial begin
    word_t w;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    quiet      = 1'b0;
    drained    = 1'b0;
    tx_count   = 0;
    rst_ni     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, empty step, saturation, ignored slot, singular.
    send_tx(step_tx('0, '0, '0));
    send_tx(load_tx(0, W_MAX));
    send_tx(load_tx(1, W_MIN));
    send_tx(load_tx(5, W_MAX));
    send_tx(step_tx('1, W_MAX, W_MIN));
    send_tx(step_tx('1, W_MIN, W_MAX));
    send_tx(load_tx(31, W_MAX));
    send_tx(load_tx(18, W_MIN));
    for (int i = 0; i < 9; i++) send_tx(load_tx(i, '0));
    // Zero the top orientation row: determinant collapses.
    for (int i = 9; i < 12; i++) send_tx(load_tx(i, '0));
    send_tx(step_tx(DT_BITS'(16), '0, '0));
    send_tx(load_tx(9, ONE_Q));
    send_tx(step_tx(DT_BITS'(1), word_t'(1), word_t'(-1)));

    // Random: steps, orientation reloads, single loads and ignored loads.
    while (tx_count < TX_TOTAL) begin
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        send_tx(random_step());
      end else if (sel < 75) begin
        for (int i = 0; i < 9; i++) begin
          w = (i % 4 == 0) ? ONE_Q : '0;
          w = w + word_t'($urandom_range(0, 1 << 13)) - (1 << 12);
          if ($urandom_range(0, 19) == 0) w = '0;
          send_tx(load_tx(9 + i, w));
        end
      end else if (sel < 90) begin
        w = ($urandom_range(0, 1) == 0) ? word_t'($urandom)
                                        : word_t'($urandom_range(0, 1 << 18)) - (1 << 17);
        send_tx(load_tx($urandom_range(0, NUM_LOAD - 1), w));
      end else begin
        send_tx(load_tx($urandom_range(NUM_LOAD, 31), word_t'($urandom)));
      end
      // Drain once mid-run after a step, with the sender held off.
      if (!drained && sel < 60 && tx_count >= 200) begin
        drained = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (words_pending != 0) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (900) @(posedge clk_i);
    if (err_count == 0 && words_pending == 0) begin
      $display("[rigid_body_euler_step] OK");
    end else begin
      $display("[rigid_body_euler_step] ERROR");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/core/rbes_pkg.sv
rtl/core/rbes_div.sv
rtl/core/rbes_dp.sv
rtl/core/rbes_ctrl.sv
rtl/core/rigid_body_euler_step.sv
verif/rigid_body_euler_step_checker.sv
verif/rigid_body_euler_step_test.sv
